// ===== hdl/rpca_pkg.sv =====
// Shared types, constants and constant tables for the pixel colour adjust block.
`default_nettype none

package rpca_pkg;

    // Adjustment modes held in the mode register.
    typedef enum logic [1:0] {
        MODE_PASS     = 2'd0,
        MODE_CONTRAST = 2'd1,
        MODE_SAT      = 2'd2,
        MODE_LIGHT    = 2'd3
    } adjust_mode_t;

    // Configuration register indexes.
    localparam logic [7:0] CFG_IDX_MODE   = 8'd0;
    localparam logic [7:0] CFG_IDX_FACTOR = 8'd1;

    // Number of register stages from input to output word.
    localparam int NUM_STAGES = 13;

    // Reciprocals for exact division of 32-bit values by 5 and by 3.
    localparam logic [31:0] RECIP_5 = 32'hCCCC_CCCD;
    localparam logic [31:0] RECIP_3 = 32'hAAAA_AAAB;

    // Input and result words.
    typedef struct packed {
        logic [7:0] blue_in;
        logic [7:0] green_in;
        logic [7:0] red_in;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] blue_out;
        logic [7:0] green_out;
        logic [7:0] red_out;
    } pixel_out_t;

    // Per-channel hand-over from the front end to the exponent pipeline.
    typedef struct packed {
        logic        fixed;
        logic [7:0]  fixed_byte;
        logic [30:0] y;
        logic [7:0]  g_lo;
        logic [3:0]  n;
    } front_out_t;

    typedef logic signed [19:0] log_tab_t [256];
    typedef logic [31:0]        k_tab_t [17];
    typedef logic [30:0]        exp_tab_t [256];

    // Integer square root, floored; used only while building tables.
    function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] bv;
        n   = n_in;
        res = 64'd0;
        bv  = 64'h4000_0000_0000_0000;
        while (bv > n) bv = bv >> 2;
        while (bv != 64'd0) begin
            if (n >= res + bv) begin
                n   = n - (res + bv);
                res = (res >> 1) + bv;
            end else begin
                res = res >> 1;
            end
            bv = bv >> 2;
        end
        return res;
    endfunction

    // log2 of the normalised channel in signed Q16, one entry per byte value.
    function automatic log_tab_t build_log_tab();
        log_tab_t    tab;
        logic [16:0] c;
        logic [63:0] m;
        logic [15:0] frac;
        int          p;
        int          val;
        tab[0] = 20'sd0;
        for (int v = 1; v < 256; v++) begin
            c    = 17'(v * 257 + 1);
            p    = 16;
            frac = 16'd0;
            while (p > 0 && c[p] == 1'b0) p--;
            m = 64'(c) << (30 - p);
            for (int k = 0; k < 16; k++) begin
                m    = (m * m) >> 30;
                frac = {frac[14:0], 1'b0};
                if (m >= 64'h8000_0000) begin
                    frac[0] = 1'b1;
                    m       = m >> 1;
                end
            end
            val    = (p - 16) * 65536 + int'(frac);
            tab[v] = 20'(val);
        end
        return tab;
    endfunction

    // Successive square roots of two in Q1.30.
    function automatic k_tab_t build_k_tab();
        k_tab_t tab;
        tab[0] = 32'h8000_0000;
        for (int k = 1; k < 17; k++) begin
            tab[k] = 32'(isqrt64(64'(tab[k-1]) << 30));
        end
        return tab;
    endfunction

    localparam k_tab_t K_TAB = build_k_tab();

    // 2^g for the upper eight fraction bits, truncated after every factor.
    function automatic exp_tab_t build_exp_hi_tab();
        exp_tab_t    tab;
        logic [63:0] y;
        logic [7:0]  gh;
        for (int i = 0; i < 256; i++) begin
            gh = 8'(i);
            y  = 64'h4000_0000;
            for (int k = 1; k < 9; k++) begin
                if (gh[8-k]) y = (y * 64'(K_TAB[k])) >> 30;
            end
            tab[i] = y[30:0];
        end
        return tab;
    endfunction

    localparam log_tab_t LOG_TAB    = build_log_tab();
    localparam exp_tab_t EXP_HI_TAB = build_exp_hi_tab();

    // Signed Q16 result to a clamped byte.
    function automatic logic [7:0] q16_to_byte(input logic signed [26:0] r);
        logic [24:0] t;
        t = 25'(r[16:0]) * 25'd255;
        if (r <= 27'sd0) return 8'd0;
        if (r >= 27'sd65794) return 8'hFF;
        return t[23:16];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/rpca_front.sv =====
// Front end: normalise, log lookup, factor products, constant divides and mode select.
`default_nettype none

module rpca_front (
    input  wire logic                       aclk,
    input  wire logic [3:0]                 stage_en,
    input  wire rpca_pkg::pixel_in_t        pixel,
    input  wire rpca_pkg::adjust_mode_t     mode,
    input  wire logic signed [15:0]         factor,
    output rpca_pkg::front_out_t            lane_out [3]
);

    logic [7:0]         v_in [3];
    logic [16:0]        c_in [3];
    logic [18:0]        c_sum;
    logic signed [18:0] d_in [3];

    logic [7:0]         v1_reg [3];
    logic [16:0]        c1_reg [3];
    logic signed [19:0] lg1_reg [3];
    logic signed [18:0] d1_reg [3];

    logic [7:0]         v2_reg [3];
    logic [16:0]        c2_reg [3];
    logic signed [35:0] pc2_reg [3];
    logic signed [34:0] ps2_reg [3];

    logic [7:0]         v3_reg [3];
    logic [16:0]        c3_reg [3];
    logic [23:0]        qc3_reg [3];
    logic               nc3_reg [3];
    logic [23:0]        qs3_reg [3];
    logic               ns3_reg [3];

    rpca_pkg::front_out_t out_reg [3];

    assign v_in[0] = pixel.blue_in;
    assign v_in[1] = pixel.green_in;
    assign v_in[2] = pixel.red_in;

    // Channel as an unsigned Q16 fraction: ceil(v * 65536 / 255) = 257 v + (v != 0).
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_in[i] = 17'({v_in[i], 8'd0}) + 17'(v_in[i]) + 17'(v_in[i] != 8'd0);
        end
        c_sum = 19'(c_in[0]) + 19'(c_in[1]) + 19'(c_in[2]);
        for (int i = 0; i < 3; i++) begin
            d_in[i] = signed'(19'(({2'b0, c_in[i]} << 1) + {2'b0, c_in[i]} - c_sum));
        end
    end

    // Stage one: normalised channel, its logarithm and its distance from the mean.
    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            for (int i = 0; i < 3; i++) begin
                v1_reg[i]  <= v_in[i];
                c1_reg[i]  <= c_in[i];
                lg1_reg[i] <= rpca_pkg::LOG_TAB[v_in[i]];
                d1_reg[i]  <= d_in[i];
            end
        end
    end

    // Stage two: products with the factor.
    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            for (int i = 0; i < 3; i++) begin
                v2_reg[i]  <= v1_reg[i];
                c2_reg[i]  <= c1_reg[i];
                pc2_reg[i] <= 36'(lg1_reg[i]) * 36'(factor);
                ps2_reg[i] <= 35'(d1_reg[i]) * 35'(factor);
            end
        end
    end

    // Stage three: divide magnitudes by 2560 and 768, truncating toward zero.
    logic [35:0] pc_mag [3];
    logic [34:0] ps_mag [3];
    logic [57:0] qc_prod [3];
    logic [56:0] qs_prod [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pc_mag[i]  = pc2_reg[i][35] ? 36'(-pc2_reg[i]) : 36'(pc2_reg[i]);
            ps_mag[i]  = ps2_reg[i][34] ? 35'(-ps2_reg[i]) : 35'(ps2_reg[i]);
            qc_prod[i] = 58'(pc_mag[i][34:9]) * 58'(rpca_pkg::RECIP_5);
            qs_prod[i] = 57'(ps_mag[i][32:8]) * 57'(rpca_pkg::RECIP_3);
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            for (int i = 0; i < 3; i++) begin
                v3_reg[i]  <= v2_reg[i];
                c3_reg[i]  <= c2_reg[i];
                qc3_reg[i] <= qc_prod[i][57:34];
                nc3_reg[i] <= pc2_reg[i][35];
                qs3_reg[i] <= qs_prod[i][56:33];
                ns3_reg[i] <= ps2_reg[i][34];
            end
        end
    end

    // Stage four: per-mode result, or exponent split for the contrast power.
    rpca_pkg::front_out_t lane_next [3];
    logic signed [26:0]   c_s [3];
    logic signed [26:0]   r_sat [3];
    logic signed [26:0]   r_light [3];
    logic [19:0]          n_sum [3];
    logic [15:0]          g_frac [3];
    logic                 f_pos;

    always_comb begin
        f_pos = !factor[15] && (factor != 16'sd0);
        for (int i = 0; i < 3; i++) begin
            c_s[i]     = signed'({10'd0, c3_reg[i]});
            r_sat[i]   = ns3_reg[i] ? c_s[i] - signed'({3'd0, qs3_reg[i]})
                                    : c_s[i] + signed'({3'd0, qs3_reg[i]});
            r_light[i] = c_s[i] + signed'({{3{factor[15]}}, factor, 8'd0});
            n_sum[i]   = 20'(qc3_reg[i][18:0]) + 20'd65535;
            g_frac[i]  = 16'(~qc3_reg[i][15:0]) + 16'd1;

            lane_next[i].fixed      = 1'b1;
            lane_next[i].fixed_byte = 8'd0;
            lane_next[i].y          = rpca_pkg::EXP_HI_TAB[g_frac[i][15:8]];
            lane_next[i].g_lo       = g_frac[i][7:0];
            lane_next[i].n          = n_sum[i][19:16];

            unique case (mode)
                rpca_pkg::MODE_PASS: begin
                    lane_next[i].fixed_byte = v3_reg[i];
                end
                rpca_pkg::MODE_SAT: begin
                    lane_next[i].fixed_byte = rpca_pkg::q16_to_byte(r_sat[i]);
                end
                rpca_pkg::MODE_LIGHT: begin
                    lane_next[i].fixed_byte = rpca_pkg::q16_to_byte(r_light[i]);
                end
                rpca_pkg::MODE_CONTRAST: begin
                    if (v3_reg[i] == 8'd0) begin
                        // A zero channel goes to black for a positive power, else white.
                        lane_next[i].fixed_byte = f_pos ? 8'd0 : 8'hFF;
                    end else if (!nc3_reg[i] || qc3_reg[i] == 24'd0) begin
                        lane_next[i].fixed_byte = 8'hFF;
                    end else if (qc3_reg[i][23:19] != 5'd0) begin
                        lane_next[i].fixed_byte = 8'd0;
                    end else begin
                        lane_next[i].fixed = 1'b0;
                    end
                end
                default: begin
                    lane_next[i].fixed_byte = v3_reg[i];
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[3]) begin
            for (int i = 0; i < 3; i++) begin
                out_reg[i] <= lane_next[i];
            end
        end
    end

    assign lane_out = out_reg;

endmodule

`default_nettype wire

// ===== hdl/rpca_exp.sv =====
// One channel of the power-of-two pipeline: eight factor stages and the byte stage.
`default_nettype none

module rpca_exp (
    input  wire logic                  aclk,
    input  wire logic [8:0]            stage_en,
    input  wire rpca_pkg::front_out_t  lane_in,
    output logic [7:0]                 byte_out
);

    rpca_pkg::front_out_t st_src [8];
    rpca_pkg::front_out_t st_next [8];
    rpca_pkg::front_out_t st_reg [8];
    logic [61:0]          prod [8];
    logic [7:0]           byte_reg;

    always_comb begin
        st_src[0] = lane_in;
        for (int j = 1; j < 8; j++) begin
            st_src[j] = st_reg[j-1];
        end
    end

    // Each stage multiplies in the root of two for one lower fraction bit.
    for (genvar j = 0; j < 8; j++) begin : g_step
        assign prod[j] = 62'(st_src[j].y) * 62'(rpca_pkg::K_TAB[9+j][30:0]);
    end

    always_comb begin
        for (int j = 0; j < 8; j++) begin
            st_next[j] = st_src[j];
            if (st_src[j].g_lo[7-j]) begin
                st_next[j].y = prod[j][60:30];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < 8; j++) begin
            if (stage_en[j]) begin
                st_reg[j] <= st_next[j];
            end
        end
    end

    // Byte stage: scale by 255 and shift down by 30 + n, clamped.
    logic [38:0] scaled;
    logic [38:0] shifted;
    logic [7:0]  byte_next;

    always_comb begin
        scaled  = 39'(st_reg[7].y) * 39'd255;
        shifted = scaled >> (6'd30 + 6'(st_reg[7].n));
        if (st_reg[7].fixed) begin
            byte_next = st_reg[7].fixed_byte;
        end else if (shifted > 39'd255) begin
            byte_next = 8'hFF;
        end else begin
            byte_next = shifted[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[8]) begin
            byte_reg <= byte_next;
        end
    end

    assign byte_out = byte_reg;

endmodule

`default_nettype wire

// ===== hdl/rgb_pixel_color_adjust_top.sv =====
// Top level of the pixel colour adjust block: config registers, stage control, lanes.
//
// Pixel colour adjustment, one 24-bit pixel word per clock while the receiver keeps up.
// Input words arrive on s_valid/s_ready/s_data (blue, green, red bytes); results
// leave on m_valid/m_ready/m_data. The mode and signed Q8.8 factor registers are
// written through cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is always high
// and writes to indexes other than 0 and 1 are dropped. Write them only while no
// word is in flight.
// A word passes 13 register stages; m_valid rises once it reaches the last. A new
// word can be taken every cycle while the receiver keeps up; the depth is set by
// the eight chained Q1.30 multiplies of the power-of-two step, one per stage, after
// four front stages for log lookup, factor product, constant divide and mode select,
// and before the byte stage.
// Every stage carries a valid bit and loads whenever it is empty or the stage after
// it moves, so bubbles close up while the receiver stalls; s_ready falls only when
// all 13 stages hold words. The last stage is the output register, which holds its
// word until m_ready.
// Reset clears all valid bits, sets the mode to pass-through and the factor to zero.
`default_nettype none

module rgb_pixel_color_adjust_top (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire rpca_pkg::pixel_in_t     s_data,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output rpca_pkg::pixel_out_t         m_data,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [7:0]              cfg_index,
    input  wire logic [15:0]             cfg_data
);

    rpca_pkg::adjust_mode_t mode_reg;
    logic signed [15:0]     factor_reg;
    logic [rpca_pkg::NUM_STAGES-1:0] vld_reg;
    logic [rpca_pkg::NUM_STAGES-1:0] stage_en;
    rpca_pkg::front_out_t   lane [3];
    logic [7:0]             byte_res [3];

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= rpca_pkg::MODE_PASS;
            factor_reg <= 16'sd0;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == rpca_pkg::CFG_IDX_MODE) begin
                mode_reg <= rpca_pkg::adjust_mode_t'(cfg_data[1:0]);
            end else if (cfg_index == rpca_pkg::CFG_IDX_FACTOR) begin
                factor_reg <= signed'(cfg_data);
            end
        end
    end

    // A stage loads when it is empty or its successor moves on.
    always_comb begin
        stage_en[rpca_pkg::NUM_STAGES-1] = !vld_reg[rpca_pkg::NUM_STAGES-1] || m_ready;
        for (int i = rpca_pkg::NUM_STAGES - 2; i >= 0; i--) begin
            stage_en[i] = !vld_reg[i] || stage_en[i+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (stage_en[0]) vld_reg[0] <= s_valid;
            for (int i = 1; i < rpca_pkg::NUM_STAGES; i++) begin
                if (stage_en[i]) vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    assign s_ready = stage_en[0];
    assign m_valid = vld_reg[rpca_pkg::NUM_STAGES-1];

    // Front end for all three channels.
    rpca_front u_front (
        .aclk     (aclk),
        .stage_en (stage_en[3:0]),
        .pixel    (s_data),
        .mode     (mode_reg),
        .factor   (factor_reg),
        .lane_out (lane)
    );

    // One power-of-two pipeline per channel.
    for (genvar i = 0; i < 3; i++) begin : g_lane
        rpca_exp u_exp (
            .aclk     (aclk),
            .stage_en (stage_en[12:4]),
            .lane_in  (lane[i]),
            .byte_out (byte_res[i])
        );
    end

    assign m_data.blue_out  = byte_res[0];
    assign m_data.green_out = byte_res[1];
    assign m_data.red_out   = byte_res[2];

    // Input is refused only when every stage holds a word.
    a_full_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (&vld_reg))
        else $error("input refused with a free pipeline stage");

    // A word in stage 5 moving forward into a free or moving stage 6 is not lost.
    a_word_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[5] && stage_en[6]) |=> vld_reg[6])
        else $error("word lost between pipeline stages");

    // Reset leaves no result pending.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

`default_nettype wire
